>>> design/kcwg_pkg.sv
// ----------------------------------------------------------------------------
// kcwg_pkg
// Shared types and constants of the KeeLoq code word generator.
// ----------------------------------------------------------------------------
package kcwg_pkg;

	localparam logic [31:0] KL_NLF      = 32'h3A5C_742E;
	localparam int          KL_ROUNDS   = 528;
	localparam int          RND_W       = $clog2(KL_ROUNDS);
	localparam int          KEY_W       = 64;
	localparam int          WORD_W      = 32;
	localparam int          SERIAL_W    = 28;
	localparam int          BTN_W       = 4;
	localparam int          CNT_W       = 16;
	localparam int          DISC_W      = 12;
	localparam int          CFG_DATA_W  = 64;
	localparam int          CFG_IDX_W   = 2;

	// tags that replace the button nibble for device key derivation
	localparam logic [BTN_W-1:0] TAG_KEY_LO = 4'h2;
	localparam logic [BTN_W-1:0] TAG_KEY_HI = 4'h6;

	// fixed discriminators
	localparam logic [DISC_W-1:0] DISC_MERLIN    = 12'h000;
	localparam logic [DISC_W-1:0] DISC_CENTURION = 12'h1CE;
	localparam logic [DISC_W-1:0] DISC_MONARCH   = 12'h100;
	localparam logic [1:0]        DISC_PARITY    = 2'b11;
	localparam logic [3:0]        DISC_DEAMIO    = 4'hC;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MFR_KEY  = 2'd0,
		REG_LEARNING = 2'd1,
		REG_FORMAT   = 2'd2,
		REG_SERIAL   = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		FMT_GENERIC   = 3'd0,
		FMT_SERIAL12  = 3'd1,
		FMT_SERIAL8   = 3'd2,
		FMT_MERLIN    = 3'd3,
		FMT_CENTURION = 3'd4,
		FMT_MONARCH   = 3'd5,
		FMT_APRIMATIC = 3'd6,
		FMT_DEAMIO    = 3'd7
	} hop_fmt_t;

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} kl_op_t;

	typedef struct packed {
		logic   start;
		kl_op_t op;
	} cipher_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY_LO,
		ST_KEY_HI,
		ST_ENC,
		ST_HOLD
	} state_t;

endpackage

>>> design/kcwg_word.sv
// ----------------------------------------------------------------------------
// kcwg_word
// Builds the fixed word and the hop word from button, counter and serial.
// ----------------------------------------------------------------------------
module kcwg_word (
	input  logic [kcwg_pkg::BTN_W-1:0]    btn,
	input  logic [kcwg_pkg::CNT_W-1:0]    cnt,
	input  logic [kcwg_pkg::SERIAL_W-1:0] serial,
	input  kcwg_pkg::hop_fmt_t            fmt,
	output logic [kcwg_pkg::WORD_W-1:0]   fixed,
	output logic [kcwg_pkg::WORD_W-1:0]   hop
);

	logic [kcwg_pkg::DISC_W-1:0] disc;

	always_comb begin
		unique case (fmt)
			kcwg_pkg::FMT_GENERIC:   disc = {2'b00, serial[9:0]};
			kcwg_pkg::FMT_SERIAL12:  disc = serial[11:0];
			kcwg_pkg::FMT_SERIAL8:   disc = {4'h0, serial[7:0]};
			kcwg_pkg::FMT_MERLIN:    disc = kcwg_pkg::DISC_MERLIN;
			kcwg_pkg::FMT_CENTURION: disc = kcwg_pkg::DISC_CENTURION;
			kcwg_pkg::FMT_MONARCH:   disc = kcwg_pkg::DISC_MONARCH;
			// mark bits 11..10 when serial[9:0] has even parity
			kcwg_pkg::FMT_APRIMATIC: disc = {(^serial[9:0]) ? 2'b00 : kcwg_pkg::DISC_PARITY,
				serial[9:0]};
			kcwg_pkg::FMT_DEAMIO:    disc = {kcwg_pkg::DISC_DEAMIO + {2'b00, serial[9:8]},
				serial[7:0]};
			default:                 disc = '0;
		endcase
	end

	assign fixed = {btn, serial};
	assign hop   = {btn, disc, cnt};

endmodule

>>> design/kcwg_cipher.sv
// ----------------------------------------------------------------------------
// kcwg_cipher
// KeeLoq NLFSR, one round per cycle; encrypt or decrypt, 528 rounds.
// ----------------------------------------------------------------------------
module kcwg_cipher (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kcwg_pkg::cipher_ctl_t         ctl,
	input  logic [kcwg_pkg::WORD_W-1:0]   data,
	input  logic [kcwg_pkg::KEY_W-1:0]    key,
	output logic                          done,
	output logic [kcwg_pkg::WORD_W-1:0]   result
);

	logic [kcwg_pkg::WORD_W-1:0] x_q;
	logic [kcwg_pkg::KEY_W-1:0]  key_q;
	logic [kcwg_pkg::RND_W-1:0]  rnd_q;
	logic                        busy_q;
	logic                        done_q;
	kcwg_pkg::kl_op_t            op_q;
	logic [4:0]                  idx_enc;
	logic [4:0]                  idx_dec;
	logic                        fb_enc;
	logic                        fb_dec;
	logic                        last;

	assign idx_enc = {x_q[31], x_q[26], x_q[20], x_q[9], x_q[1]};
	assign idx_dec = {x_q[30], x_q[25], x_q[19], x_q[8], x_q[0]};
	assign fb_enc  = x_q[0] ^ x_q[16] ^ key_q[0] ^ kcwg_pkg::KL_NLF[idx_enc];
	assign fb_dec  = x_q[31] ^ x_q[15] ^ key_q[15] ^ kcwg_pkg::KL_NLF[idx_dec];
	assign last    = rnd_q == kcwg_pkg::RND_W'(kcwg_pkg::KL_ROUNDS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
			op_q   <= kcwg_pkg::OP_ENCRYPT;
		end else begin
			done_q <= busy_q && last;
			if (ctl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
				op_q   <= ctl.op;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 1'b1;
				if (last)
					busy_q <= 1'b0;
			end
		end
	end

	// encrypt walks the key upwards from bit 0, decrypt downwards from bit 15
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q   <= data;
			key_q <= key;
		end else if (busy_q) begin
			if (op_q == kcwg_pkg::OP_ENCRYPT) begin
				x_q   <= {fb_enc, x_q[31:1]};
				key_q <= {key_q[0], key_q[63:1]};
			end else begin
				x_q   <= {x_q[30:0], fb_dec};
				key_q <= {key_q[62:0], key_q[63]};
			end
		end
	end

	assign done   = done_q;
	assign result = x_q;

endmodule

>>> design/keeloq_code_word_generator_top.sv
// ----------------------------------------------------------------------------
// keeloq_code_word_generator_top
// Rolling-code encoder: fixed word plus KeeLoq-encrypted hop word per press.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid, in_ready, button_code,          | sink
//          | rolling_counter                           |
//  out     | out_valid, out_ready, fixed_word,         | source
//          | encrypted_hop                             |
//  cfg     | cfg_wr_en, cfg_index, cfg_data            | sink, write only
//
// One cipher engine runs one round a cycle.
// Simple learning: out_valid rises once the word is encrypted and the register
// is free; normal learning runs two decryptions for the device key first.
// One word at a time; the result register frees the engine, and a stalled
// output holds the finished ciphertext until the register drains.
// Reset clears the configuration and control registers and leaves the block
// idle; the data registers keep whatever they held.
module keeloq_code_word_generator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [kcwg_pkg::BTN_W-1:0]        button_code,
	input  logic [kcwg_pkg::CNT_W-1:0]        rolling_counter,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [kcwg_pkg::WORD_W-1:0]       fixed_word,
	output logic [kcwg_pkg::WORD_W-1:0]       encrypted_hop,
	input  logic                              cfg_wr_en,
	input  logic [kcwg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kcwg_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [kcwg_pkg::KEY_W-1:0]    mfr_key_q;
	logic                          learning_q;
	kcwg_pkg::hop_fmt_t            format_q;
	logic [kcwg_pkg::SERIAL_W-1:0] serial_q;

	kcwg_pkg::state_t              state_q;
	kcwg_pkg::state_t              state_d;
	logic [kcwg_pkg::BTN_W-1:0]    btn_q;
	logic [kcwg_pkg::CNT_W-1:0]    cnt_q;
	logic [kcwg_pkg::WORD_W-1:0]   k1_q;
	logic                          out_valid_q;
	logic [kcwg_pkg::WORD_W-1:0]   fixed_q;
	logic [kcwg_pkg::WORD_W-1:0]   hop_out_q;

	kcwg_pkg::cipher_ctl_t         ctl;
	logic [kcwg_pkg::WORD_W-1:0]   c_data;
	logic [kcwg_pkg::KEY_W-1:0]    c_key;
	logic                          c_done;
	logic [kcwg_pkg::WORD_W-1:0]   c_result;

	logic                          idle;
	logic                          accept;
	logic                          load_out;
	logic                          out_free;
	logic [kcwg_pkg::BTN_W-1:0]    w_btn;
	logic [kcwg_pkg::CNT_W-1:0]    w_cnt;
	logic [kcwg_pkg::WORD_W-1:0]   w_fixed;
	logic [kcwg_pkg::WORD_W-1:0]   w_hop;

	assign idle     = state_q == kcwg_pkg::ST_IDLE;
	assign in_ready = idle;
	assign accept   = in_valid && idle;
	assign out_free = !out_valid_q || out_ready;

	// words come straight from the ports while the press is being taken
	assign w_btn = idle ? button_code : btn_q;
	assign w_cnt = idle ? rolling_counter : cnt_q;

	kcwg_word u_word (
		.btn    (w_btn),
		.cnt    (w_cnt),
		.serial (serial_q),
		.fmt    (format_q),
		.fixed  (w_fixed),
		.hop    (w_hop)
	);

	kcwg_cipher u_cipher (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.data   (c_data),
		.key    (c_key),
		.done   (c_done),
		.result (c_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mfr_key_q  <= '0;
			learning_q <= 1'b0;
			format_q   <= kcwg_pkg::FMT_GENERIC;
			serial_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (kcwg_pkg::cfg_reg_t'(cfg_index))
				kcwg_pkg::REG_MFR_KEY:  mfr_key_q  <= cfg_data[kcwg_pkg::KEY_W-1:0];
				kcwg_pkg::REG_LEARNING: learning_q <= cfg_data[0];
				kcwg_pkg::REG_FORMAT:   format_q   <= kcwg_pkg::hop_fmt_t'(cfg_data[2:0]);
				kcwg_pkg::REG_SERIAL:   serial_q   <= cfg_data[kcwg_pkg::SERIAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= kcwg_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		ctl.start = 1'b0;
		ctl.op    = kcwg_pkg::OP_ENCRYPT;
		c_data    = w_hop;
		c_key     = mfr_key_q;
		load_out  = 1'b0;
		unique case (state_q)
			kcwg_pkg::ST_IDLE: begin
				if (in_valid) begin
					ctl.start = 1'b1;
					if (learning_q) begin
						ctl.op  = kcwg_pkg::OP_DECRYPT;
						c_data  = {kcwg_pkg::TAG_KEY_LO, serial_q};
						state_d = kcwg_pkg::ST_KEY_LO;
					end else begin
						state_d = kcwg_pkg::ST_ENC;
					end
				end
			end
			kcwg_pkg::ST_KEY_LO: begin
				if (c_done) begin
					ctl.start = 1'b1;
					ctl.op    = kcwg_pkg::OP_DECRYPT;
					c_data    = {kcwg_pkg::TAG_KEY_HI, serial_q};
					state_d   = kcwg_pkg::ST_KEY_HI;
				end
			end
			kcwg_pkg::ST_KEY_HI: begin
				if (c_done) begin
					ctl.start = 1'b1;
					c_key     = {c_result, k1_q};
					state_d   = kcwg_pkg::ST_ENC;
				end
			end
			kcwg_pkg::ST_ENC: begin
				if (c_done) begin
					if (out_free) begin
						load_out = 1'b1;
						state_d  = kcwg_pkg::ST_IDLE;
					end else begin
						state_d  = kcwg_pkg::ST_HOLD;
					end
				end
			end
			kcwg_pkg::ST_HOLD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = kcwg_pkg::ST_IDLE;
				end
			end
			default: state_d = kcwg_pkg::ST_IDLE;
		endcase
	end

	// hold the press, the low half of the device key and the output words
	always_ff @(posedge clk) begin
		if (accept) begin
			btn_q <= button_code;
			cnt_q <= rolling_counter;
		end
		if (state_q == kcwg_pkg::ST_KEY_LO && c_done)
			k1_q <= c_result;
		if (load_out) begin
			fixed_q   <= w_fixed;
			hop_out_q <= c_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid     = out_valid_q;
	assign fixed_word    = fixed_q;
	assign encrypted_hop = hop_out_q;

endmodule
